### rtl/array_max_priority_queue_top_macros.svh
// Assertion macros for the array max priority queue RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef ARRAY_MAX_PRIORITY_QUEUE_TOP_MACROS_SVH
`define ARRAY_MAX_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define APQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apq assertion failed");
`define APQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apq assertion failed");
`else
`define APQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define APQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/apq_pkg.sv
// Shared codes and controller/datapath interface types for the priority queue.
// No dependencies.
`default_nettype none
package apq_pkg;

  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int OCC_W = 4;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              load_in;
    logic              st_load;
    logic [STS_W-1:0]  st_code;
    logic              enq_write;
    logic              rd_first;
    logic              peek_take;
    logic              scan_step;
    logic              shift_begin;
    logic              shift_step;
    logic              dec_count;
    logic              out_load;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              empty;
    logic              full;
    logic              scan_last;
    logic              best_is_last;
    logic              shift_last;
  } sts_t;

endpackage
`default_nettype wire

### rtl/apq_datapath.sv
// Datapath: entry memory, count, shared scan/shift pointer, result registers.
// Depends on apq_pkg and the assertion macro header.
`default_nettype none
`include "array_max_priority_queue_top_macros.svh"
module apq_datapath #(
  parameter int DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire apq_pkg::ctl_t                     ctl,
  output apq_pkg::sts_t                          sts,
  input  wire logic [apq_pkg::CMD_W-1:0]         command,
  input  wire logic signed [apq_pkg::VAL_W-1:0]  value,
  output logic signed [apq_pkg::VAL_W-1:0]       result_value,
  output logic [apq_pkg::STS_W-1:0]              status,
  output logic [apq_pkg::OCC_W-1:0]              occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [apq_pkg::VAL_W-1:0] mem [DEPTH];
  logic signed [apq_pkg::VAL_W-1:0] rdata;
  logic [AW-1:0]                    raddr;
  logic                             we;
  logic [AW-1:0]                    waddr;
  logic signed [apq_pkg::VAL_W-1:0] wdata;

  logic [CW-1:0]                    count;
  logic [apq_pkg::CMD_W-1:0]        cmd_reg;
  logic signed [apq_pkg::VAL_W-1:0] val_reg;
  logic [AW-1:0]                    ptr;
  logic signed [apq_pkg::VAL_W-1:0] best_val;
  logic [AW-1:0]                    best_idx;
  logic signed [apq_pkg::VAL_W-1:0] res;
  logic [apq_pkg::STS_W-1:0]        st;
  logic                             take;
  logic [CW+apq_pkg::OCC_W-1:0]     occ_ext;

  always_comb begin
    raddr = ptr + AW'(1);
    if (ctl.rd_first) begin
      raddr = '0;
    end else if (ctl.shift_begin) begin
      raddr = best_idx + AW'(1);
    end else if (ctl.shift_step) begin
      raddr = ptr + AW'(2);
    end
  end

  assign we    = ctl.enq_write | ctl.shift_step;
  assign waddr = ctl.enq_write ? count[AW-1:0] : ptr;
  assign wdata = ctl.enq_write ? val_reg : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign take = (ptr == '0) || (rdata > best_val);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.enq_write) begin
      count <= count + CW'(1);
    end else if (ctl.dec_count) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_reg <= command;
      val_reg <= value;
    end
    if (ctl.rd_first) begin
      ptr <= '0;
    end else if (ctl.shift_begin) begin
      ptr <= best_idx;
    end else if (ctl.scan_step || ctl.shift_step) begin
      ptr <= ptr + AW'(1);
    end
    if (ctl.scan_step && take) begin
      best_val <= rdata;
      best_idx <= ptr;
    end
    if (ctl.st_load) begin
      st  <= ctl.st_code;
      res <= '0;
    end else if (ctl.peek_take) begin
      res <= rdata;
    end else if (ctl.shift_begin) begin
      res <= best_val;
    end
  end

  assign occ_ext = {{apq_pkg::OCC_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result_value <= res;
      status       <= st;
      occupancy    <= occ_ext[apq_pkg::OCC_W-1:0];
    end
  end

  assign sts.cmd          = cmd_reg;
  assign sts.empty        = (count == '0);
  assign sts.full         = (count >= CW'(DEPTH));
  assign sts.scan_last    = (CW'(ptr) == count - CW'(1));
  assign sts.best_is_last = (CW'(best_idx) == count - CW'(1));
  assign sts.shift_last   = (CW'(ptr) + CW'(2) == count);

  `APQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `APQ_ASSERT_NOW(a_enq_room, clk, rst, ctl.enq_write, count < CW'(DEPTH))
  `APQ_ASSERT_NOW(a_ptr_in_range, clk, rst, ctl.scan_step || ctl.shift_step,
                  CW'(ptr) < count)

endmodule
`default_nettype wire

### rtl/apq_controller.sv
// Controller state machine: sequences enqueue, peek, scan and shift steps.
// Depends on apq_pkg and the assertion macro header.
`default_nettype none
`include "array_max_priority_queue_top_macros.svh"
module apq_controller (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire apq_pkg::sts_t sts,
  output apq_pkg::ctl_t      ctl
);

  localparam logic [2:0] S_IDLE        = 3'd0;
  localparam logic [2:0] S_DECODE      = 3'd1;
  localparam logic [2:0] S_PEEK_WAIT   = 3'd2;
  localparam logic [2:0] S_SCAN        = 3'd3;
  localparam logic [2:0] S_SHIFT_BEGIN = 3'd4;
  localparam logic [2:0] S_SHIFT       = 3'd5;
  localparam logic [2:0] S_FINISH      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.st_load = 1'b1;
        ctl.st_code = apq_pkg::ST_OK;
        state_next  = S_FINISH;
        unique case (sts.cmd)
          apq_pkg::CMD_ENQUEUE: begin
            if (sts.full) begin
              ctl.st_code = apq_pkg::ST_FULL;
            end else begin
              ctl.enq_write = 1'b1;
            end
          end
          apq_pkg::CMD_DEQUEUE: begin
            if (sts.empty) begin
              ctl.st_code = apq_pkg::ST_EMPTY;
            end else begin
              ctl.rd_first = 1'b1;
              state_next   = S_SCAN;
            end
          end
          apq_pkg::CMD_PEEK: begin
            if (sts.empty) begin
              ctl.st_code = apq_pkg::ST_EMPTY;
            end else begin
              ctl.rd_first = 1'b1;
              state_next   = S_PEEK_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_PEEK_WAIT: begin
        ctl.peek_take = 1'b1;
        state_next    = S_FINISH;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SHIFT_BEGIN;
        end
      end
      S_SHIFT_BEGIN: begin
        ctl.shift_begin = 1'b1;
        if (sts.best_is_last) begin
          ctl.dec_count = 1'b1;
          state_next    = S_FINISH;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ctl.shift_step = 1'b1;
        if (sts.shift_last) begin
          ctl.dec_count = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `APQ_ASSERT_NOW(a_no_overwrite, clk, rst, ctl.out_load, !out_valid || out_ready)
  `APQ_ASSERT_NEXT(a_load_shows, clk, rst, ctl.out_load, out_valid && state == S_IDLE)
  `APQ_ASSERT_NOW(a_single_step, clk, rst, 1'b1,
                  $onehot0({ctl.scan_step, ctl.shift_begin, ctl.shift_step, ctl.rd_first}))

endmodule
`default_nettype wire

### rtl/array_max_priority_queue_top.sv
// Bounded max priority queue kept as an unsorted array in insertion order.
// Top level; instantiates apq_controller and apq_datapath, uses apq_pkg.
//
// Input channel (in_valid/in_ready, command, value): one command per transfer:
// enqueue value, dequeue the largest entry (oldest on ties), or peek the
// oldest entry. Output channel (out_valid/out_ready): one result per command
// with result_value, status (ok, full, empty) and occupancy after the step.
// Commands run one at a time. From a transfer to its result in the output
// register: enqueue, empty peek or dequeue and unknown codes go from decode
// straight to the finish step, peek waits for one memory read, and dequeue
// with n stored entries scans all n, then moves the n - 1 - k entries above
// the removed slot k down one place. The dequeue work is set by the single
// read port of the entry memory: one entry per cycle for the maximum search,
// then one entry per cycle to close the gap.
// A new command is taken while a finished result still waits in the output
// register; a stalled receiver holds only the last step before the output
// register load. Reset empties the queue and drops any pending result;
// memory contents are left as they are; unwritten slots never reach a result.
`default_nettype none
module array_max_priority_queue_top #(
  parameter int DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [apq_pkg::CMD_W-1:0]         command,
  input  wire logic signed [apq_pkg::VAL_W-1:0]  value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [apq_pkg::VAL_W-1:0]       result_value,
  output logic [apq_pkg::STS_W-1:0]              status,
  output logic [apq_pkg::OCC_W-1:0]              occupancy
);

  apq_pkg::ctl_t ctl;
  apq_pkg::sts_t sts;

  apq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  apq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .command      (command),
    .value        (value),
    .result_value (result_value),
    .status       (status),
    .occupancy    (occupancy)
  );

endmodule
`default_nettype wire
